// ===== src/lcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lcd_pkg;

    localparam int ENTRIES     = 8;
    localparam int SLOT_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS    = $clog2(ENTRIES + 1);
    localparam int KEY_BITS    = 32;
    localparam int HANDLE_BITS = 32;
    localparam int STAMP_BITS  = 32;

    typedef enum logic [1:0] {
        OP_STORE    = 2'd0,
        OP_LOOKUP   = 2'd1,
        OP_COMPLETE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        RC_HIT      = 3'd0,
        RC_PENDING  = 3'd1,
        RC_NO_SLOT  = 3'd2,
        RC_STORED   = 3'd3,
        RC_ABSENT   = 3'd4,
        RC_COMPLETE = 3'd5
    } rc_t;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_LOAD    = 2'd1,
        CMD_REPLACE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_READY   = 2'd1,
        ST_READ    = 2'd2,
        ST_REPLACE = 2'd3
    } slot_st_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_MATCH,
        FSM_VICTIM,
        FSM_APPLY
    } fsm_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] data_handle;
        logic        key_exists;
        logic [2:0]  entry;
    } req_t;

    typedef struct packed {
        logic [2:0]  result_code;
        logic [2:0]  slot;
        logic [31:0] data_out;
        logic [1:0]  command;
        logic [31:0] old_key;
        logic [31:0] new_key;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load_req;
        logic scan_clr;
        logic scan_step;
        logic apply;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
        logic is_complete;
        logic hit;
        logic empty_found;
    } sts_t;

endpackage
`default_nettype wire

// ===== src/lcd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lcd_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [1:0]     op,
    output logic                busy,
    output lcd_pkg::ctl_t       ctl,
    input  lcd_pkg::sts_t       sts
);
    import lcd_pkg::*;

    fsm_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FSM_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (start && (op == OP_STORE || op == OP_LOOKUP))
                    state_next = FSM_MATCH;
                else if (start && op == OP_COMPLETE)
                    state_next = FSM_APPLY;
            end
            FSM_MATCH:
            begin
                if (sts.hit)
                    state_next = FSM_APPLY;
                else if (sts.scan_last)
                    state_next = FSM_VICTIM;
            end
            FSM_VICTIM:
            begin
                if (sts.empty_found || sts.scan_last)
                    state_next = FSM_APPLY;
            end
            FSM_APPLY: state_next = FSM_IDLE;
            default:   state_next = FSM_IDLE;
        endcase
    end

    always_comb
    begin
        ctl  = '0;
        busy = 1'b1;
        unique case (state_reg)
            FSM_IDLE:
            begin
                busy         = 1'b0;
                ctl.load_req = start;
                ctl.scan_clr = 1'b1;
            end
            FSM_MATCH:
            begin
                ctl.scan_step = !sts.hit;
                ctl.scan_clr  = sts.scan_last && !sts.hit;
            end
            FSM_VICTIM: ctl.scan_step = !sts.empty_found;
            FSM_APPLY:  ctl.apply = 1'b1;
            default:    busy = 1'b1;
        endcase
    end
endmodule
`default_nettype wire

// ===== src/lcd_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lcd_dpath (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  lcd_pkg::req_t   req,
    input  lcd_pkg::ctl_t   ctl,
    output lcd_pkg::sts_t   sts,
    output logic            rsp_valid,
    output lcd_pkg::rsp_t   rsp
);
    import lcd_pkg::*;

    slot_st_t               status_reg [ENTRIES];
    logic [KEY_BITS-1:0]    key_reg    [ENTRIES];
    logic [KEY_BITS-1:0]    pkey_reg   [ENTRIES];
    logic [HANDLE_BITS-1:0] data_reg   [ENTRIES];
    logic [HANDLE_BITS-1:0] pdata_reg  [ENTRIES];
    logic                   exists_reg [ENTRIES];
    logic [STAMP_BITS-1:0]  stamp_reg  [ENTRIES];
    logic [STAMP_BITS-1:0]  counter_reg;

    req_t                   req_reg;
    logic [CNT_BITS-1:0]    idx_reg;
    logic                   hit_reg, pick_ok_reg, empty_reg;
    logic [SLOT_BITS-1:0]   pick_reg;
    logic [STAMP_BITS-1:0]  pick_stamp_reg;
    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg;
    rsp_t                   rsp_next;

    logic [SLOT_BITS-1:0]   idx;
    logic                   cur_hit, cur_empty, cur_better;
    logic [SLOT_BITS-1:0]   s;
    logic                   have;
    slot_st_t               st;
    logic [SLOT_BITS-1:0]   ent;
    logic                   ent_ok;

    assign idx        = idx_reg[SLOT_BITS-1:0];
    assign cur_hit    = status_reg[idx] != ST_EMPTY && key_reg[idx] == req_reg.key;
    assign cur_empty  = status_reg[idx] == ST_EMPTY;
    assign cur_better = status_reg[idx] == ST_READY &&
                        (!pick_ok_reg || stamp_reg[idx] < pick_stamp_reg);
    assign sts.scan_last   = idx_reg == CNT_BITS'(ENTRIES - 1);
    assign sts.hit         = cur_hit;
    assign sts.empty_found = cur_empty;
    assign sts.is_complete = req_reg.op == OP_COMPLETE;

    assign s    = hit_reg ? pick_reg : (empty_reg ? pick_reg : pick_reg);
    assign have = hit_reg || empty_reg || pick_ok_reg;
    assign st   = status_reg[s];
    assign ent  = SLOT_BITS'(req_reg.entry);
    assign ent_ok = {1'b0, req_reg.entry} < 4'(ENTRIES);

    always_comb
    begin
        rsp_next = '0;
        if (req_reg.op == OP_COMPLETE)
        begin
            rsp_next.result_code = RC_COMPLETE;
            rsp_next.slot        = req_reg.entry;
        end
        else if (!have)
            rsp_next.result_code = RC_NO_SLOT;
        else
        begin
            rsp_next.slot = 3'(s);
            if (hit_reg && req_reg.op == OP_STORE)
                rsp_next.result_code = RC_STORED;
            else if (hit_reg)
            begin
                if (st != ST_READY)
                    rsp_next.result_code = RC_PENDING;
                else if (!exists_reg[s])
                    rsp_next.result_code = RC_ABSENT;
                else
                begin
                    rsp_next.result_code = RC_HIT;
                    rsp_next.data_out    = data_reg[s];
                end
            end
            else if (req_reg.op == OP_STORE)
            begin
                rsp_next.result_code = RC_STORED;
                if (st == ST_READY)
                begin
                    rsp_next.command = CMD_REPLACE;
                    rsp_next.old_key = key_reg[s];
                    rsp_next.new_key = req_reg.key;
                end
            end
            else if (st == ST_READY)
            begin
                rsp_next.result_code = req_reg.key_exists ? RC_PENDING : RC_ABSENT;
                rsp_next.command     = CMD_REPLACE;
                rsp_next.old_key     = key_reg[s];
                rsp_next.new_key     = req_reg.key;
            end
            else if (req_reg.key_exists)
            begin
                rsp_next.result_code = RC_PENDING;
                rsp_next.command     = CMD_LOAD;
                rsp_next.new_key     = req_reg.key;
            end
            else
                rsp_next.result_code = RC_ABSENT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_req)
            req_reg <= req;
        if (ctl.scan_clr)
        begin
            idx_reg     <= '0;
            pick_ok_reg <= 1'b0;
            empty_reg   <= 1'b0;
            if (ctl.load_req)
                hit_reg <= 1'b0;
        end
        else if (ctl.scan_step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (cur_better)
            begin
                pick_ok_reg    <= 1'b1;
                pick_reg       <= idx;
                pick_stamp_reg <= stamp_reg[idx];
            end
        end
        else if (!ctl.apply)
        begin
            // scan stopped on a hit or an empty slot
            pick_reg <= idx;
            if (cur_hit)
                hit_reg <= 1'b1;
            if (cur_empty)
                empty_reg <= 1'b1;
        end
        if (ctl.apply)
            rsp_reg <= rsp_next;
        else
            rsp_reg <= '0;
        // key stores have undefined reset
        if (ctl.apply && req_reg.op != OP_COMPLETE && have && !hit_reg)
        begin
            if (st == ST_READY)
                pkey_reg[s] <= req_reg.key;
            else
                key_reg[s] <= req_reg.key;
        end
        if (ctl.apply && req_reg.op == OP_COMPLETE && ent_ok &&
            status_reg[ent] == ST_REPLACE)
            key_reg[ent] <= pkey_reg[ent];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            counter_reg   <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                status_reg[i] <= ST_EMPTY;
                data_reg[i]   <= '0;
                pdata_reg[i]  <= '0;
                exists_reg[i] <= 1'b0;
                stamp_reg[i]  <= '0;
            end
        end
        else
        begin
            rsp_valid_reg <= ctl.apply;
            if (ctl.apply && req_reg.op == OP_COMPLETE)
            begin
                if (ent_ok && status_reg[ent] == ST_READ)
                begin
                    data_reg[ent]   <= req_reg.data_handle;
                    status_reg[ent] <= ST_READY;
                end
                else if (ent_ok && status_reg[ent] == ST_REPLACE)
                begin
                    if (pdata_reg[ent] != '0)
                        data_reg[ent] <= pdata_reg[ent];
                    else
                        data_reg[ent] <= exists_reg[ent] ? req_reg.data_handle : '0;
                    pdata_reg[ent]  <= '0;
                    status_reg[ent] <= ST_READY;
                end
            end
            else if (ctl.apply && have)
            begin
                if (hit_reg)
                begin
                    if (req_reg.op == OP_STORE)
                    begin
                        data_reg[s]   <= req_reg.data_handle;
                        exists_reg[s] <= 1'b1;
                    end
                    else if (st == ST_READY)
                    begin
                        stamp_reg[s] <= counter_reg;
                        counter_reg  <= counter_reg + 1'b1;
                    end
                end
                else
                begin
                    stamp_reg[s] <= counter_reg;
                    counter_reg  <= counter_reg + 1'b1;
                    exists_reg[s] <= (req_reg.op == OP_STORE) ? 1'b1 : req_reg.key_exists;
                    if (st == ST_READY)
                    begin
                        pdata_reg[s]  <= (req_reg.op == OP_STORE) ? req_reg.data_handle : '0;
                        status_reg[s] <= ST_REPLACE;
                    end
                    else if (req_reg.op == OP_STORE)
                    begin
                        data_reg[s]   <= req_reg.data_handle;
                        status_reg[s] <= ST_READY;
                    end
                    else
                        status_reg[s] <= req_reg.key_exists ? ST_READ : ST_READY;
                end
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
endmodule
`default_nettype wire

// ===== src/lru_cache_directory_with_pending_fills.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Fully associative LRU directory of eight slots with pending fills. Pulse
// start with a request while busy is low; exactly one result transfer follows
// on done, held for one cycle, and the receiver cannot stall it. A store or
// lookup walks the slots one per cycle: a match scan, then on a miss a victim
// scan, and a completion goes straight to the apply step; done rises in the
// cycle after the apply step, alongside the next accept. Ops outside 0..2
// give no result and leave the block idle.
module lru_cache_directory_with_pending_fills (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  lcd_pkg::req_t  req,
    output logic           busy,
    output logic           done,
    output lcd_pkg::rsp_t  rsp
);
    import lcd_pkg::*;

    ctl_t ctl;
    sts_t sts;

    lcd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (req.op),
        .busy  (busy),
        .ctl   (ctl),
        .sts   (sts)
    );

    lcd_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ctl       (ctl),
        .sts       (sts),
        .rsp_valid (done),
        .rsp       (rsp)
    );

`ifndef SYNTHESIS
    // a result only follows an apply cycle
    a_done_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(ctl.apply)) else $error("done without apply");
    // never accept while applying
    a_apply_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.apply |-> busy) else $error("apply while idle");
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rsp.result_code <= RC_COMPLETE) else $error("bad code");
`endif
endmodule
`default_nettype wire
